[rtl/core/stable_priority_queue_defines.svh]
// ----------------------------------------------------------------------------
// stable_priority_queue_defines.svh
// Assertion macros for the checker file of the priority queue.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication under the asynchronous active-low reset.
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("priority queue check failed: same-cycle implication");

// Next-cycle implication under the asynchronous active-low reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("priority queue check failed: next-cycle implication");

`endif

[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and sizes shared by the priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 5;
	localparam int VAL_W = 32;
	localparam int PRI_W = 8;
	localparam int ST_W  = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [PRI_W-1:0]        prio;
		logic signed [VAL_W-1:0] value;
	} spq_entry_t;

	localparam int ENTRY_W = $bits(spq_entry_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		spq_entry_t       wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} spq_mem_req_t;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] removed_value;
		logic [OCC_W-1:0]        occupancy;
	} spq_rsp_t;

endpackage

[rtl/core/spq_if.sv]
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for queue requests and queue results.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic signed [spq_pkg::VAL_W-1:0] value;
	logic [spq_pkg::PRI_W-1:0]        priority_req;

	modport source (output valid, output op, output value, output priority_req, input ready);
	modport sink (input valid, input op, input value, input priority_req, output ready);
endinterface

interface spq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [spq_pkg::ST_W-1:0]         status;
	logic signed [spq_pkg::VAL_W-1:0] removed_value;
	logic [spq_pkg::OCC_W-1:0]        occupancy;

	modport source (output valid, output status, output removed_value, output occupancy,
		input ready);
	modport sink (input valid, input status, input removed_value, input occupancy,
		output ready);
endinterface

[rtl/core/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: walks the sorted slot RAM one entry at a time with a single
// priority comparator, shifting entries to open or close a gap.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             req_op,
	input  logic signed [spq_pkg::VAL_W-1:0] req_value,
	input  logic [spq_pkg::PRI_W-1:0]        req_prio,
	output spq_pkg::spq_mem_req_t            mem,
	input  spq_pkg::spq_entry_t              rd_entry,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output spq_pkg::spq_rsp_t                rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_NEW,
		S_REM_RD,
		S_REM_HEAD,
		S_REM_WR,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [spq_pkg::IDX_W-1:0]         idx_q;
	logic [spq_pkg::CNT_W-1:0]         count_q;
	logic [spq_pkg::CNT_W-1:0]         count_next;
	spq_pkg::spq_entry_t               new_q;
	logic [spq_pkg::ST_W-1:0]          status_q;
	logic signed [spq_pkg::VAL_W-1:0]  head_q;
	logic                              inc_q;
	logic                              dec_q;
	logic                              later;

	// shared comparator: stored entry ranks after the new one
	assign later = rd_entry.prio > new_q.prio;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_DONE);

	always_comb begin
		count_next = count_q;
		if (inc_q) begin
			count_next = count_q + spq_pkg::CNT_W'(1);
		end else if (dec_q) begin
			count_next = count_q - spq_pkg::CNT_W'(1);
		end
	end

	assign rsp.status        = status_q;
	assign rsp.removed_value = head_q;
	assign rsp.occupancy     = spq_pkg::OCC_W'(count_next);

	always_comb begin
		mem = '0;
		unique case (state_q)
			S_INS_RD: begin
				mem.re    = 1'b1;
				mem.raddr = idx_q;
			end
			S_INS_CMP: begin
				mem.we    = 1'b1;
				mem.waddr = idx_q + spq_pkg::IDX_W'(1);
				mem.wdata = later ? rd_entry : new_q;
			end
			S_INS_NEW: begin
				mem.we    = 1'b1;
				mem.wdata = new_q;
			end
			S_REM_RD: begin
				mem.re    = 1'b1;
				mem.raddr = idx_q;
			end
			S_REM_WR: begin
				mem.we    = 1'b1;
				mem.waddr = idx_q - spq_pkg::IDX_W'(1);
				mem.wdata = rd_entry;
			end
			default: begin
				mem = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			count_q  <= '0;
			new_q    <= '0;
			status_q <= spq_pkg::ST_DONE;
			head_q   <= '0;
			inc_q    <= 1'b0;
			dec_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						new_q    <= '{prio: req_prio, value: req_value};
						status_q <= spq_pkg::ST_DONE;
						head_q   <= '0;
						inc_q    <= 1'b0;
						dec_q    <= 1'b0;
						if (req_op == spq_pkg::OP_INSERT) begin
							if (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
								status_q <= spq_pkg::ST_FULL;
								state_q  <= S_DONE;
							end else if (count_q == '0) begin
								inc_q   <= 1'b1;
								state_q <= S_INS_NEW;
							end else begin
								inc_q   <= 1'b1;
								idx_q   <= spq_pkg::IDX_W'(count_q - spq_pkg::CNT_W'(1));
								state_q <= S_INS_RD;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= spq_pkg::ST_UNDERFLOW;
								state_q  <= S_DONE;
							end else begin
								dec_q   <= 1'b1;
								idx_q   <= '0;
								state_q <= S_REM_RD;
							end
						end
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (later) begin
						if (idx_q == '0) begin
							state_q <= S_INS_NEW;
						end else begin
							idx_q   <= idx_q - spq_pkg::IDX_W'(1);
							state_q <= S_INS_RD;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_INS_NEW: begin
					state_q <= S_DONE;
				end
				S_REM_RD: begin
					state_q <= (idx_q == '0) ? S_REM_HEAD : S_REM_WR;
				end
				S_REM_HEAD: begin
					head_q <= rd_entry.value;
					if (count_q == spq_pkg::CNT_W'(1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= spq_pkg::IDX_W'(1);
						state_q <= S_REM_RD;
					end
				end
				S_REM_WR: begin
					if (spq_pkg::CNT_W'(idx_q) == count_q - spq_pkg::CNT_W'(1)) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + spq_pkg::IDX_W'(1);
						state_q <= S_REM_RD;
					end
				end
				S_DONE: begin
					if (rsp_ready) begin
						count_q <= count_next;
						inc_q   <= 1'b0;
						dec_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue held in sorted order in a slot RAM; lower priority
// numbers are served first and equal priorities keep arrival order.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake    payload
//  req      in   valid/ready  op, value, priority_req
//  rsp      out  valid/ready  status, removed_value, occupancy
//
//  An insert walks from the tail with a read step and a write step for each
//  stored entry that ranks after the new one; a remove reads the head, then
//  moves each later entry up one slot; a full insert or empty remove goes
//  straight to its result. All of it is set by the slot RAM's registered read,
//  one entry moved per read and write step, under one comparator.
//  Reset clears the fill count; slot contents are never cleared, as only
//  slots below the count are read. A stalled result sits in the output
//  register while the next item is accepted and worked on.
//
module stable_priority_queue (
	input  logic clk,
	input  logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	spq_pkg::spq_mem_req_t           mem;
	logic [spq_pkg::ENTRY_W-1:0]     rd_bits;
	spq_pkg::spq_entry_t             rd_entry;
	spq_pkg::spq_rsp_t               ctrl_rsp;
	logic                            ctrl_rsp_valid;
	logic                            ctrl_rsp_ready;
	spq_pkg::spq_rsp_t               rsp_q;
	logic                            rsp_valid_q;

	assign rd_entry = spq_pkg::spq_entry_t'(rd_bits);

	// sequencer with the shared priority comparator
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_op    (req.op),
		.req_value (req.value),
		.req_prio  (req.priority_req),
		.mem       (mem),
		.rd_entry  (rd_entry),
		.rsp_valid (ctrl_rsp_valid),
		.rsp_ready (ctrl_rsp_ready),
		.rsp       (ctrl_rsp)
	);

	// sorted slot store, slot 0 is the head
	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (spq_pkg::DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_bits)
	);

	// output register: take a new result when empty or being drained
	assign ctrl_rsp_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (ctrl_rsp_valid && ctrl_rsp_ready) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= ctrl_rsp;
			end else if (rsp.ready) begin
				// drop the item once taken
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.removed_value = rsp_q.removed_value;
	assign rsp.occupancy     = rsp_q.occupancy;

endmodule

[rtl/core/spq_chk.sv]
// ----------------------------------------------------------------------------
// spq_chk
// Port-level checks for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [spq_pkg::ST_W-1:0]         rsp_status,
	input logic signed [spq_pkg::VAL_W-1:0] rsp_removed_value,
	input logic [spq_pkg::OCC_W-1:0]        rsp_occupancy
);

	logic rsp_stall;
	logic took_req;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign took_req  = req_valid && req_ready;

	// a held result keeps its payload
	`SPQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_removed_value) && $stable(rsp_status))
	// underflow only from an empty queue
	`SPQ_ASSERT_IMPLY(a_underflow_empty, clk, arst_n, rsp_valid && rsp_status == spq_pkg::ST_UNDERFLOW, rsp_occupancy == '0)
	// full only when every slot is taken
	`SPQ_ASSERT_IMPLY(a_full_depth, clk, arst_n, rsp_valid && rsp_status == spq_pkg::ST_FULL, rsp_occupancy == spq_pkg::OCC_W'(spq_pkg::DEPTH))
	// one item at a time: busy right after an accept
	`SPQ_ASSERT_NEXT(a_busy_after_take, clk, arst_n, took_req, !req_ready)

endmodule

bind stable_priority_queue spq_chk u_spq_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_removed_value (rsp.removed_value),
	.rsp_occupancy     (rsp.occupancy)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_priority_queue. Run directed and random
// insert/remove items through the request channel and check every result
// against a sorted-array predictor that is updated as each item is accepted.
// Both sides idle and stall at random. One long receiver hold-off fills the
// block and stalls its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 6;
	// Slowest item is a remove from a full queue.
	localparam int DRAIN_CYCLES    = 2 * spq_pkg::DEPTH + 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS    = 1350;
	localparam int TAIL_ITEMS      = 200;
	localparam int MAX_REPORTS     = 10;
	// About 1600 items, each at worst an idle gap, a remove from a full queue and
	// a receiver stall, plus the hold-off; taken several times over.
	localparam int CYCLE_LIMIT     = 400000;

	logic clk;
	logic arst_n;

	spq_req_if req ();
	spq_rsp_if rsp ();

	stable_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Predictor state: sorted entries, slot 0 is the head.
	spq_pkg::spq_entry_t sorted_slot [spq_pkg::DEPTH];
	int                  stored_count;

	// Results still owed by the block, oldest first.
	spq_pkg::spq_rsp_t   owed_results [$];

	int mismatch_count;
	int cycle_count;

	// Idling switch shared by both sides; cleared for quiet stretches and the tail.
	bit idle_on;
	// Ask the receiver process for one long hold-off.
	bit hold_request;

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: apply one accepted item to the sorted array and return the
	// result the block owes for it.
	// ------------------------------------------------------------------------
	function automatic spq_pkg::spq_rsp_t apply_queue_op(input logic op,
		input logic signed [spq_pkg::VAL_W-1:0] value,
		input logic [spq_pkg::PRI_W-1:0] prio);
		spq_pkg::spq_rsp_t r;
		int                pos;
		r.status        = spq_pkg::ST_DONE;
		r.removed_value = '0;
		if (op == spq_pkg::OP_INSERT) begin
			if (stored_count >= spq_pkg::DEPTH) begin
				// Full: leave the contents untouched.
				r.status = spq_pkg::ST_FULL;
			end else begin
				// Go in after every entry of lower or equal priority number,
				// so ties keep arrival order.
				pos = 0;
				while (pos < stored_count && sorted_slot[pos].prio <= prio)
					pos++;
				for (int i = stored_count; i > pos; i--)
					sorted_slot[i] = sorted_slot[i-1];
				sorted_slot[pos].prio  = prio;
				sorted_slot[pos].value = value;
				stored_count++;
			end
		end else if (stored_count == 0) begin
			r.status = spq_pkg::ST_UNDERFLOW;
		end else begin
			r.removed_value = sorted_slot[0].value;
			for (int i = 1; i < stored_count; i++)
				sorted_slot[i-1] = sorted_slot[i];
			stored_count--;
		end
		r.occupancy = spq_pkg::OCC_W'(stored_count);
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// Sender: offer one item, with an optional idle burst first, and hold it
	// until the block takes it. Called at a rising edge, returns at the
	// accepting edge without touching valid, so back-to-back items keep valid
	// high with no drop in between.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic op,
		input logic signed [spq_pkg::VAL_W-1:0] value,
		input logic [spq_pkg::PRI_W-1:0] prio);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.op           <= op;
		req.value        <= value;
		req.priority_req <= prio;
		do @(posedge clk); while (!req.ready);
		// Item taken at this edge: work out its result now.
		owed_results.push_back(apply_queue_op(op, value, prio));
	endtask

	// One random item; insert_pct sets the mix, narrow packs priorities close
	// together so that ties are common.
	task automatic send_random_item(input int insert_pct, input bit narrow);
		logic                             op;
		logic signed [spq_pkg::VAL_W-1:0] value;
		logic [spq_pkg::PRI_W-1:0]        prio;
		op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
		case ($urandom_range(0, 15))
			0: value = 32'sh7FFF_FFFF;
			1: value = 32'sh8000_0000;
			default: value = $urandom;
		endcase
		if (narrow)
			prio = spq_pkg::PRI_W'($urandom_range(0, 3));
		else begin
			case ($urandom_range(0, 15))
				0: prio = '0;
				1: prio = '1;
				default: prio = spq_pkg::PRI_W'($urandom_range(0, 255));
			endcase
		end
		send_item(op, value, prio);
	endtask

	// Pause the sender until every owed result has come back.
	task automatic wait_for_results();
		req.valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold-off counted here.
	// ------------------------------------------------------------------------
	initial begin
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 11);
			if (!arst_n) begin
				rsp.ready <= 1'b0;
			end else if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker: every accepted result against the oldest owed one.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		spq_pkg::spq_rsp_t owed;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (owed_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result status %0d value %0d occ %0d",
					rsp.status, rsp.removed_value, rsp.occupancy));
			end else begin
				owed = owed_results.pop_front();
				if (rsp.status !== owed.status)
					flag_mismatch($sformatf("status exp %0d got %0d",
						owed.status, rsp.status));
				if (rsp.removed_value !== owed.removed_value)
					flag_mismatch($sformatf("removed_value exp %0d got %0d",
						owed.removed_value, rsp.removed_value));
				if (rsp.occupancy !== owed.occupancy)
					flag_mismatch($sformatf("occupancy exp %0d got %0d",
						owed.occupancy, rsp.occupancy));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[stable_priority_queue] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Empty removes, value and priority extremes, ties at both ends of the
	// priority range, then drain past empty.
	task automatic test_directed_extremes();
		send_item(spq_pkg::OP_REMOVE, 32'sh1234_5678, 8'd9);
		send_item(spq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 8'd255);
		send_item(spq_pkg::OP_INSERT, 32'sh8000_0000, 8'd0);
		send_item(spq_pkg::OP_INSERT, 32'sh0000_0000, 8'd0);
		send_item(spq_pkg::OP_INSERT, -32'sd1, 8'd128);
		send_item(spq_pkg::OP_INSERT, 32'sh0000_0001, 8'd255);
		send_item(spq_pkg::OP_INSERT, 32'sh5555_AAAA, 8'd127);
		repeat (6) send_item(spq_pkg::OP_REMOVE, 32'shFFFF_FFFF, 8'd255);
		send_item(spq_pkg::OP_REMOVE, 32'sh0000_0000, 8'd0);
		wait_for_results();
	endtask

	// Hold the receiver off while inserts keep coming, so the block stalls its
	// input; once released the queue overflows into full results. Then pause
	// the sender and drain past empty.
	task automatic test_full_backpressure();
		hold_request = 1'b1;
		repeat (spq_pkg::DEPTH + 8) send_random_item(100, 1'b1);
		wait_for_results();
		repeat (spq_pkg::DEPTH + 1) send_random_item(0, 1'b0);
		wait_for_results();
	endtask

	// Rounds of fill-heavy, drain-heavy and balanced traffic, with narrow or
	// wide priorities, and quiet rounds with no idling on either side.
	task automatic test_random_traffic();
		int sent;
		int round_len;
		int insert_pct;
		bit narrow;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			round_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 20;
				default: insert_pct = 55;
			endcase
			narrow  = ($urandom_range(0, 1) == 0);
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (round_len) send_random_item(insert_pct, narrow);
			sent += round_len;
		end
		idle_on = 1'b1;
	endtask

	// Last stretch at full rate: no idling on either side.
	task automatic test_full_rate_tail();
		idle_on = 1'b0;
		repeat (TAIL_ITEMS) send_random_item(55, $urandom_range(0, 1) == 0);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		mismatch_count = 0;
		cycle_count    = 0;
		stored_count   = 0;
		idle_on        = 1'b1;
		hold_request   = 1'b0;

		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.op           <= spq_pkg::OP_INSERT;
		req.value        <= '0;
		req.priority_req <= '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_full_backpressure();
		test_random_traffic();
		test_full_rate_tail();

		// Drop valid, collect the rest, then give stray results time to show.
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && owed_results.size() == 0) begin
			$display("[stable_priority_queue] OK");
		end else begin
			$display("[stable_priority_queue] ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_ram.sv
rtl/core/spq_ctrl.sv
rtl/core/stable_priority_queue.sv
rtl/core/spq_chk.sv
tb/tb.sv
